FILE: src/swks_pkg.sv
// Shared types and constants for the sliding-window k-smallest-sum core.
`timescale 1ns / 1ps
package swks_pkg;

  localparam int unsigned SAMPLE_W  = 32;  // width of the sample port
  localparam int unsigned SUM_W     = 38;  // width of the result sum
  localparam int unsigned CFG_W     = 7;   // width of the widest config register
  localparam int unsigned CFG_IDX_W = 1;   // config register index width

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K_COUNT    = 1'd1;

  // per-cycle command broadcast to every cell of the sorted chain
  typedef struct packed {
    logic rem;  // drop first entry >= key, upper entries slide down
    logic ins;  // insert key in order, upper entries slide up
  } swks_cell_ctl_t;

endpackage

FILE: src/swks_ring.sv
// Ring memory holding the recent samples in arrival order.
`timescale 1ns / 1ps
module swks_ring #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read-before-write: the old entry comes out while the new one goes in
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rdata_q      <= mem_q[addr_i];
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/swks_cell.sv
// One cell of the sorted chain: holds one sample and trades with its neighbors.
`timescale 1ns / 1ps
module swks_cell
  import swks_pkg::*;
#(
  parameter int unsigned DATA_W = 32
) (
  input  logic           clk_i,
  input  swks_cell_ctl_t ctl_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic           valid_i,     // cell index below fill count
  input  logic [DATA_W-1:0] prev_val_i,
  input  logic           prev_gt_i,   // lower neighbor empty or above key
  input  logic [DATA_W-1:0] next_val_i,
  output logic [DATA_W-1:0] val_o,
  output logic           gt_o
);

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;
  logic              ge;

  assign gt_o = !valid_i || (val_q > key_i);
  assign ge   = valid_i && (val_q >= key_i);

  always_comb begin
    val_d = val_q;
    if (ctl_i.rem) begin
      if (ge) begin
        val_d = next_val_i;
      end
    end else if (ctl_i.ins) begin
      if (gt_o) begin
        val_d = prev_gt_i ? prev_val_i : key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

FILE: src/sliding_window_k_smallest_sum_core.sv
// Top level of the sliding-window k-smallest-sum core.
// Each sample steps through accept, remove oldest and insert newest; the result is registered
//   in the insert step, and no new sample is accepted until that step is done. The sorted
//   cell chain does one shift per cycle; a stalled result holds the insert step.
// A config write sweeps the min(k_count, window, fill) smallest into the sum; no sample taken.
// Reset (rst_ni low, async) empties the window and sets window_len = k_count = 1.
`timescale 1ns / 1ps
module sliding_window_k_smallest_sum_core
  import swks_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample requests
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SAMPLE_W-1:0]  sample_i,
  // result requests
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SUM_W-1:0]     smallest_sum_o,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_W = $clog2(WINDOW_MAX + 1);

  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a sample
    S_REM,   // oldest sample leaves the sorted chain
    S_INS,   // new sample enters the sorted chain, result issued
    S_SUM    // rebuild the running sum after a config write
  } state_e;

  state_e                 state_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   rem_q;
  logic [IDX_W-1:0]       ptr_q;
  logic [LEN_W-1:0]       fill_q;
  logic [LEN_W-1:0]       sweep_q;
  logic [CFG_W-1:0]       window_len_q;
  logic [CFG_W-1:0]       k_count_q;
  logic [SUM_W-1:0]       sum_q;
  logic                   out_valid_q;
  logic [SUM_W-1:0]       out_sum_q;

  logic [SAMPLE_BITS-1:0] s_in;
  logic [LEN_W-1:0]       len;      // effective window length
  logic [LEN_W-1:0]       ke;       // effective k, clamped to len
  logic [IDX_W-1:0]       ptr_use;
  logic [IDX_W-1:0]       ptr_d;
  logic [LEN_W-1:0]       ptr_nxt;
  logic                   in_accept;
  logic                   out_free;
  logic                   rem_go;
  logic                   ins_go;
  logic [LEN_W-1:0]       fill_inc;
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic [LEN_W-1:0]       sel_a;
  logic [LEN_W-1:0]       sel_b;
  logic [SAMPLE_BITS-1:0] tap_a;
  logic [SAMPLE_BITS-1:0] tap_b;
  logic [SUM_W-1:0]       sum_rem;
  logic [SUM_W-1:0]       sum_ins;
  logic [SUM_W-1:0]       sum_tmp;
  swks_cell_ctl_t         cell_ctl;
  logic [SAMPLE_BITS-1:0] cell_key;
  logic [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
  logic                   cell_gt  [WINDOW_MAX];

  assign s_in = sample_i[SAMPLE_BITS-1:0];

  // window length: zero reads as one, saturates at the chain depth
  always_comb begin
    if (window_len_q == '0) begin
      len = LEN_W'(1);
    end else if (int'(window_len_q) > int'(WINDOW_MAX)) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(window_len_q);
    end
    if (int'(k_count_q) > int'(len)) begin
      ke = len;
    end else begin
      ke = LEN_W'(k_count_q);
    end
  end

  // ring slot for this sample and the one after it
  always_comb begin
    ptr_use = (LEN_W'(ptr_q) >= len) ? '0 : ptr_q;
    ptr_nxt = LEN_W'(ptr_use) + LEN_W'(1);
    ptr_d   = (ptr_nxt >= len) ? '0 : IDX_W'(ptr_nxt);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rem_go     = (state_q == S_REM) && rem_q;
  assign ins_go     = (state_q == S_INS) && out_free;
  assign fill_inc   = fill_q + LEN_W'(1);

  // the ring hands back the oldest sample in the cycle after accept
  swks_ring #(
    .DEPTH  (WINDOW_MAX),
    .DATA_W (SAMPLE_BITS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .addr_i  (ptr_use),
    .wdata_i (s_in),
    .rdata_o (ring_rd)
  );

  assign cell_ctl.rem = rem_go;
  assign cell_ctl.ins = ins_go;
  assign cell_key     = rem_go ? ring_rd : sample_q;

  // sorted chain, ascending from cell 0
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev_val;
    logic                   prev_gt;
    logic [SAMPLE_BITS-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_val = cell_key;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign next_val = cell_val[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    swks_cell #(
      .DATA_W (SAMPLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl),
      .key_i      (cell_key),
      .valid_i    (LEN_W'(i) < fill_q),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // two taps into the chain: the k-th smallest and the one above it,
  // or the sweep position while the sum is rebuilt
  assign sel_a = (state_q == S_SUM) ? sweep_q : (ke - LEN_W'(1));
  assign sel_b = ke;

  always_comb begin
    tap_a = '0;
    tap_b = '0;
    for (int i = 0; i < int'(WINDOW_MAX); i++) begin
      tap_a = tap_a | (cell_val[i] & {SAMPLE_BITS{LEN_W'(i) == sel_a}});
      tap_b = tap_b | (cell_val[i] & {SAMPLE_BITS{LEN_W'(i) == sel_b}});
    end
  end

  // running sum update: the leaving sample counts only if it sits among
  // the k smallest, and then the next one up moves into the k smallest
  always_comb begin
    sum_tmp = sum_q - SUM_W'(ring_rd);
    if (ke < fill_q) begin
      sum_tmp = sum_tmp + SUM_W'(tap_b);
    end
    sum_rem = ((ke != '0) && (tap_a >= ring_rd)) ? sum_tmp : sum_q;
  end

  // entering sample: joins the k smallest if fewer than k are held, or
  // pushes out the current k-th smallest when it is below it
  always_comb begin
    sum_ins = sum_q;
    if (ke != '0) begin
      if (fill_q < ke) begin
        sum_ins = sum_q + SUM_W'(sample_q);
      end else if (tap_a > sample_q) begin
        sum_ins = sum_q + SUM_W'(sample_q) - SUM_W'(tap_a);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sample_q     <= '0;
      rem_q        <= 1'b0;
      ptr_q        <= '0;
      fill_q       <= '0;
      sweep_q      <= '0;
      window_len_q <= CFG_W'(1);
      k_count_q    <= CFG_W'(1);
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
      out_sum_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            sample_q <= s_in;
            rem_q    <= (fill_q >= len);
            ptr_q    <= ptr_d;
            state_q  <= S_REM;
          end
        end
        S_REM: begin
          if (rem_q) begin
            fill_q <= fill_q - LEN_W'(1);
            sum_q  <= sum_rem;
          end
          state_q <= S_INS;
        end
        S_INS: begin
          // hold here until the output register can take a result
          if (out_free) begin
            fill_q <= fill_inc;
            sum_q  <= sum_ins;
            if (fill_inc >= len) begin
              out_valid_q <= 1'b1;
              out_sum_q   <= sum_ins;
            end
            state_q <= S_IDLE;
          end
        end
        S_SUM: begin
          if ((sweep_q < ke) && (sweep_q < fill_q)) begin
            sum_q   <= sum_q + SUM_W'(tap_a);
            sweep_q <= sweep_q + LEN_W'(1);
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // any config write restarts the sum sweep; window change empties it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_LEN: begin
            window_len_q <= cfg_data_i;
            fill_q       <= '0;
            ptr_q        <= '0;
          end
          REG_K_COUNT: begin
            k_count_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
        sum_q   <= '0;
        sweep_q <= '0;
        state_q <= S_SUM;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign smallest_sum_o = out_sum_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len)
    else $error("fill count above window length");

  a_rem_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM && rem_q) |-> (fill_q == len))
    else $error("removal from a window that is not full");

  a_out_from_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_INS))
    else $error("result issued outside the insert step");

  a_ins_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS && out_free && !cfg_we_i) |=> (state_q == S_IDLE))
    else $error("insert step did not complete");
`endif

endmodule

FILE: test/swks_checker.sv
// Scoreboard for the sliding-window k-smallest-sum core: window model and result compare.
`timescale 1ns / 1ps
module swks_checker
  import swks_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [SUM_W-1:0]     smallest_sum_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [SAMPLE_W-1:0] ring_mem   [WINDOW_MAX];
  logic [SAMPLE_W-1:0] sorted_mem [WINDOW_MAX];
  int unsigned         ring_ptr;
  int unsigned         fill_cnt;
  logic [CFG_W-1:0]    win_reg;
  logic [CFG_W-1:0]    k_reg;
  logic [SUM_W-1:0]    window_sums [$];
  logic [SUM_W-1:0]    want_sum;
  int                  mismatches;

  // Push one sample through the window; queue a sum once the window is full.
  task automatic advance_window(input logic [SAMPLE_W-1:0] raw);
    int unsigned len;
    int unsigned ptr;
    int unsigned pos;
    int unsigned k;
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] oldest;
    logic [SUM_W-1:0]    sum;
    len = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg);
    s   = raw & SAMPLE_MASK;
    ptr = ring_ptr;
    if (ptr >= len) ptr = 0;
    // full window: the oldest sample leaves the sorted store first
    if (fill_cnt >= len) begin
      oldest = ring_mem[ptr];
      pos = 0;
      while (pos < fill_cnt && sorted_mem[pos] != oldest) pos++;
      if (pos < fill_cnt) begin
        for (int unsigned i = pos; i + 1 < fill_cnt; i++) sorted_mem[i] = sorted_mem[i + 1];
        fill_cnt--;
      end
    end
    if (fill_cnt < WINDOW_MAX) begin
      pos = 0;
      while (pos < fill_cnt && sorted_mem[pos] <= s) pos++;
      for (int unsigned i = fill_cnt; i > pos; i--) sorted_mem[i] = sorted_mem[i - 1];
      sorted_mem[pos] = s;
      fill_cnt++;
    end
    ring_mem[ptr] = s;
    ptr++;
    if (ptr >= len) ptr = 0;
    ring_ptr = ptr;
    if (fill_cnt >= len) begin
      k   = (k_reg > len) ? len : k_reg;
      sum = '0;
      for (int unsigned i = 0; i < k; i++) sum += SUM_W'(sorted_mem[i]);
      window_sums.push_back(sum);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_ptr   = 0;
      fill_cnt   = 0;
      win_reg    = 7'd1;
      k_reg      = 7'd1;
      mismatches = 0;
      window_sums.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_LEN: begin
            // new window length restarts the fill
            win_reg  = cfg_data_i;
            fill_cnt = 0;
            ring_ptr = 0;
          end
          REG_K_COUNT: k_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) advance_window(sample_i);
      if (out_valid_i && !out_stall_i) begin
        if (window_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d with no sum outstanding", smallest_sum_i);
        end else begin
          // oldest outstanding sum
          want_sum = window_sums[0];
          window_sums.delete(0);
          if (smallest_sum_i !== want_sum) begin
            mismatches++;
            if (mismatches <= 10)
              $display("smallest_sum mismatch: expected %0d, got %0d", want_sum, smallest_sum_i);
          end
        end
      end
      errors_o  <= mismatches;
      pending_o <= window_sums.size();
    end
  end

endmodule

FILE: test/tb_sliding_window_k_smallest_sum_core.sv
// Stimulus, idling and verdict for the sliding-window k-smallest-sum core.
`timescale 1ns / 1ps
module tb_sliding_window_k_smallest_sum_core;
  import swks_pkg::*;

  localparam int unsigned WIN_MAX       = 64;
  localparam int unsigned SMP_BITS      = 32;
  localparam int unsigned RANDOM_ITEMS  = 850;
  // longest legal quiet stretch is a sender gap plus a sum sweep plus a stall run
  localparam int          IDLE_LIMIT    = 2000;
  // block may still be inserting a sample that yields no result
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [SAMPLE_W-1:0]  sample    = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  wire                  in_stall;
  wire                  out_valid;
  wire  [SUM_W-1:0]     smallest_sum;
  int                   errors;
  int                   pending;
  int                   idle_cycles = 0;
  int unsigned          burst_left  = 0;
  int unsigned          stall_left  = 0;

  sliding_window_k_smallest_sum_core #(
    .WINDOW_MAX (WIN_MAX),
    .SAMPLE_BITS(SMP_BITS)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_i      (sample),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .smallest_sum_o(smallest_sum),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  swks_checker #(
    .WINDOW_MAX (WIN_MAX),
    .SAMPLE_BITS(SMP_BITS)
  ) sum_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .sample_i      (sample),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .smallest_sum_i(smallest_sum),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: runs of free flow, long stalls and per-cycle coin flips.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 14);
        end
        1, 2: begin
          out_stall <= 1'b0;
          stall_left = $urandom_range(0, 19);
        end
        default: begin
          out_stall <= 1'($urandom_range(0, 1));
          stall_left = 0;
        end
      endcase
    end else begin
      stall_left--;
    end
  end

  // Watchdog: any accepted request or register write resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("[sliding_window_k_smallest_sum_core] ERROR");
    $finish;
  end

  // One sample request; bursts of random length, random gaps in between.
  // Valid is only lowered for a gap, so it never drops and rises in one step.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending, wait for every outstanding sum, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // Registers are first touched once the block is idle; a k write may follow during the sum sweep.
  task automatic configure(input bit set_len, input logic [CFG_W-1:0] len,
                           input logic [CFG_W-1:0] k);
    settle();
    if (set_len) write_reg(REG_WINDOW_LEN, len);
    write_reg(REG_K_COUNT, k);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 7);  // heavy duplicates
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 32'hFFFF_FFFE;
          default: return 32'd1;
        endcase
      end
      default: return ($urandom_range(0, 2) == 0) ? ($urandom() & 32'hF) : $urandom();
    endcase
  endfunction

  initial begin
    int unsigned          sent;
    int unsigned          eff;
    int unsigned          n;
    int unsigned          mode;
    logic [CFG_W-1:0]     w;
    logic [CFG_W-1:0]     k;
    sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: window of one, sum of one
    send_sample('0);
    send_sample('1);
    send_sample(32'd5);
    // zero window acts as one; zero k sums nothing
    configure(1'b1, 7'd0, 7'd0);
    send_sample(32'd7);
    send_sample(32'd9);
    // k far above the window clamps to it; largest samples
    configure(1'b1, 7'd3, 7'd127);
    send_sample('1);
    send_sample('1);
    send_sample('1);
    send_sample(32'd1);
    // k change keeps the window contents
    configure(1'b0, 7'd0, 7'd2);
    send_sample(32'd4);
    send_sample(32'd4);
    send_sample(32'd4);
    send_sample(32'd2);
    // duplicate values leaving the window
    configure(1'b1, 7'd4, 7'd1);
    send_sample(32'd10);
    send_sample(32'd10);
    send_sample(32'd3);
    send_sample(32'd10);
    send_sample(32'd10);

    // random phases: new window and k, enough samples to fill and slide
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = 7'd0;
        1:       w = 7'($urandom_range(65, 127));
        2:       w = 7'd64;
        3, 4:    w = 7'($urandom_range(9, 63));
        default: w = 7'($urandom_range(1, 8));
      endcase
      eff = (w == 0) ? 1 : ((w > WIN_MAX) ? WIN_MAX : w);
      case ($urandom_range(0, 4))
        0:       k = 7'd0;
        1:       k = 7'd127;
        2:       k = 7'(eff);
        3:       k = 7'($urandom_range(eff, 127));
        default: k = 7'($urandom_range(1, eff));
      endcase
      configure(1'b1, w, k);
      n    = eff + $urandom_range(4, 40);
      mode = $urandom_range(0, 3);
      for (int unsigned i = 0; i < n; i++) begin
        // occasional k rewrite in the middle of a running window
        if (i == n / 2 && $urandom_range(0, 2) == 0)
          configure(1'b0, 7'd0, 7'($urandom_range(0, 127)));
        send_sample(pick_sample(mode));
        sent++;
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("[sliding_window_k_smallest_sum_core] OK");
    end else begin
      $display("[sliding_window_k_smallest_sum_core] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/swks_pkg.sv
src/swks_ring.sv
src/swks_cell.sv
src/sliding_window_k_smallest_sum_core.sv
test/swks_checker.sv
test/tb_sliding_window_k_smallest_sum_core.sv
